// ----- src/smcs_pkg.sv -----
// Package for the sample mode and confidence statistics core.
// Holds widths, constants, controller states, operation codes and the
// command and status structs shared by the controller and the datapath.
package smcs_pkg;

  localparam int VALUE_BITS = 10;
  localparam int COUNT_BITS = 16;
  localparam int HIST_DEPTH = 1 << VALUE_BITS;
  localparam int SUM_W      = 27;
  localparam int MAG_W      = 26;
  localparam int SQ_W       = 35;
  localparam int Q_W        = 18;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_W      = 18;

  localparam int MUL_A_W = 36;
  localparam int MUL_B_W = 26;
  localparam int MUL_P_W = 62;
  localparam int DIV_N_W = 66;
  localparam int DIV_D_W = 32;
  localparam int ROOT_W  = 38;
  localparam int ITER_W  = 7;

  localparam logic [ITER_W-1:0] MUL_STEPS  = 7'd26;
  localparam logic [ITER_W-1:0] DIV_STEPS  = 7'd66;
  localparam logic [ITER_W-1:0] ROOT_STEPS = 7'd19;
  localparam logic [ROOT_W-1:0] ROOT_BIT0  = 38'd1 << 36;

  localparam logic [MUL_B_W-1:0] SCALE_NUM = 26'd38416;
  localparam logic [MUL_B_W-1:0] SCALE_DEN = 26'd10000;
  localparam logic [Q_W-1:0]     Q18MAX    = 18'h3FFFF;

  localparam logic [15:0] MIN_RESET = 16'd10;
  localparam logic [15:0] MAX_RESET = 16'd100;
  localparam logic [17:0] THR_RESET = 18'd256;

  localparam int S_TDATA_W = 16;
  localparam int M_TDATA_W = 104;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_VALUES,
    CFG_MAX_VALUES,
    CFG_CI_THRESHOLD
  } cfg_idx_t;

  typedef enum logic [3:0] {
    OP_NSQ, OP_SQ, OP_NN1, OP_VAR, OP_SD, OP_SD2,
    OP_SCALE, OP_DEN, OP_W, OP_CI, OP_MEAN
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_UPD, ST_CHK, ST_CALC, ST_NEXT, ST_OUT
  } state_t;

  typedef struct packed {
    logic clr;
    logic upd;
    logic chk;
    logic start;
    op_t  op;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic enough;
    logic done;
    logic out_busy;
  } stat_t;

  function automatic op_t next_op(input op_t op);
    op_t r;
    case (op)
      OP_NSQ:   r = OP_SQ;
      OP_SQ:    r = OP_NN1;
      OP_NN1:   r = OP_VAR;
      OP_VAR:   r = OP_SD;
      OP_SD:    r = OP_SD2;
      OP_SD2:   r = OP_SCALE;
      OP_SCALE: r = OP_DEN;
      OP_DEN:   r = OP_W;
      OP_W:     r = OP_CI;
      OP_CI:    r = OP_MEAN;
      default:  r = OP_MEAN;
    endcase
    return r;
  endfunction

endpackage

// ----- src/smcs_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// Stands alone; no package needed.
module smcs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/smcs_ctrl.sv -----
// Controller state machine: clearing pass, sample intake, sequencing of the
// arithmetic operations and hand-off to the output register. Uses smcs_pkg.
module smcs_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  smcs_pkg::stat_t stat,
  output smcs_pkg::cmd_t  cmd
);

  smcs_pkg::state_t state, state_next;
  smcs_pkg::op_t    op, op_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= smcs_pkg::ST_CLEAR;
      op    <= smcs_pkg::OP_NSQ;
    end else begin
      state <= state_next;
      op    <= op_next;
    end
  end

  always_comb begin
    state_next = state;
    op_next    = op;
    s_tready   = 1'b0;
    cmd        = '0;
    cmd.op     = op;
    case (state)
      smcs_pkg::ST_CLEAR: begin
        cmd.clr = 1'b1;
        if (stat.clr_last) state_next = smcs_pkg::ST_IDLE;
      end
      smcs_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) state_next = smcs_pkg::ST_UPD;
      end
      smcs_pkg::ST_UPD: begin
        cmd.upd    = 1'b1;
        state_next = smcs_pkg::ST_CHK;
      end
      smcs_pkg::ST_CHK: begin
        cmd.chk = 1'b1;
        if (stat.enough) begin
          op_next    = smcs_pkg::OP_NSQ;
          state_next = smcs_pkg::ST_NEXT;
        end else begin
          state_next = smcs_pkg::ST_OUT;
        end
      end
      smcs_pkg::ST_NEXT: begin
        cmd.start  = 1'b1;
        state_next = smcs_pkg::ST_CALC;
      end
      smcs_pkg::ST_CALC: begin
        if (stat.done) begin
          if (op == smcs_pkg::OP_MEAN) begin
            state_next = smcs_pkg::ST_OUT;
          end else begin
            op_next    = smcs_pkg::next_op(op);
            state_next = smcs_pkg::ST_NEXT;
          end
        end
      end
      smcs_pkg::ST_OUT: begin
        if (!stat.out_busy) begin
          cmd.load   = 1'b1;
          state_next = smcs_pkg::ST_IDLE;
        end
      end
      default: state_next = smcs_pkg::ST_CLEAR;
    endcase
  end

endmodule

// ----- src/smcs_dp.sv -----
// Datapath: histogram memory, running sums, mode tracking, configuration
// registers, shift-add multiplier, restoring divider, square root and the
// output register. Uses smcs_pkg and smcs_ram.
module smcs_dp (
  input  logic                                 clk,
  input  logic                                 rst,
  input  smcs_pkg::cmd_t                        cmd,
  output smcs_pkg::stat_t                       stat,
  input  logic [smcs_pkg::S_TDATA_W-1:0]        s_tdata,
  input  logic                                 s_accept,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [smcs_pkg::M_TDATA_W-1:0]        m_tdata,
  input  logic                                 cfg_we,
  input  logic [smcs_pkg::CFG_IDX_W-1:0]        cfg_addr,
  input  logic [smcs_pkg::CFG_W-1:0]            cfg_wdata
);

  localparam int VB = smcs_pkg::VALUE_BITS;
  localparam int CB = smcs_pkg::COUNT_BITS;

  // Configuration.
  logic [15:0] min_values, max_values, effmin;
  logic [17:0] ci_threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_values   <= smcs_pkg::MIN_RESET;
      max_values   <= smcs_pkg::MAX_RESET;
      ci_threshold <= smcs_pkg::THR_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        smcs_pkg::CFG_MIN_VALUES:   min_values   <= cfg_wdata[15:0];
        smcs_pkg::CFG_MAX_VALUES:   max_values   <= cfg_wdata[15:0];
        smcs_pkg::CFG_CI_THRESHOLD: ci_threshold <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign effmin = (min_values < 16'd2) ? 16'd2 : min_values;

  // Histogram memory and clearing pass.
  logic [VB-1:0] clr_addr, sample_reg;
  logic [CB-1:0] rdata, hist_new;
  logic          ram_we;
  logic [VB-1:0] ram_waddr;
  logic [CB-1:0] ram_wdata;

  always_ff @(posedge clk) begin
    if (rst) clr_addr <= '0;
    else if (cmd.clr) clr_addr <= clr_addr + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (s_accept) sample_reg <= s_tdata[VB-1:0];
  end

  assign hist_new  = (rdata == '1) ? rdata : rdata + 1'b1;
  assign ram_we    = cmd.clr | cmd.upd;
  assign ram_waddr = cmd.clr ? clr_addr : sample_reg;
  assign ram_wdata = cmd.clr ? '0 : hist_new;

  // The read address follows the input bus so that the count of an accepted
  // sample is ready in the cycle after the transaction.
  smcs_ram #(.WIDTH(CB), .DEPTH(smcs_pkg::HIST_DEPTH)) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (s_tdata[VB-1:0]),
    .rdata (rdata)
  );

  // Running state.
  logic [VB-1:0]                 mode_val;
  logic [CB-1:0]                 mode_cnt, count;
  logic signed [smcs_pkg::SUM_W-1:0] run_sum;
  logic [smcs_pkg::SQ_W-1:0]     run_sq;
  logic [17:0]                   last_ci;
  logic                          stats_ok;
  logic signed [VB-1:0]          s_val;
  logic [VB-1:0]                 s_mag;
  logic [2*VB-1:0]               s_sq;
  logic [smcs_pkg::SUM_W-1:0]    sum_abs;
  logic [smcs_pkg::MAG_W-1:0]    smag;

  assign s_val   = signed'(sample_reg);
  assign s_mag   = s_val[VB-1] ? VB'(-s_val) : sample_reg;
  assign s_sq    = s_mag * s_mag;
  assign sum_abs = run_sum[smcs_pkg::SUM_W-1] ? smcs_pkg::SUM_W'(-run_sum) : run_sum;
  assign smag    = sum_abs[smcs_pkg::MAG_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_val <= '0;
      mode_cnt <= '0;
      count    <= '0;
      run_sum  <= '0;
      run_sq   <= '0;
      stats_ok <= 1'b0;
    end else begin
      if (cmd.upd) begin
        if (mode_cnt == '0 || sample_reg == mode_val || hist_new > mode_cnt) begin
          mode_val <= sample_reg;
          mode_cnt <= hist_new;
        end
        if (count != '1) begin
          count   <= count + 1'b1;
          run_sum <= run_sum + smcs_pkg::SUM_W'(s_val);
          run_sq  <= run_sq + smcs_pkg::SQ_W'(s_sq);
        end
      end
      if (cmd.chk) stats_ok <= (count >= effmin);
    end
  end

  // Iterative arithmetic engine: one operation at a time.
  logic                          busy;
  logic [smcs_pkg::ITER_W-1:0]   iter;
  logic                          done;
  logic [smcs_pkg::MUL_P_W-1:0]  mul_a, mul_acc, mul_acc_n;
  logic [smcs_pkg::MUL_B_W-1:0]  mul_b;
  logic [smcs_pkg::DIV_N_W-1:0]  div_n, div_n_nx;
  logic [smcs_pkg::DIV_D_W-1:0]  div_d, div_rem, div_rem_n;
  logic [smcs_pkg::DIV_D_W:0]    div_t;
  logic                          div_ge;
  logic [smcs_pkg::ROOT_W-1:0]   rt_v, rt_r, rt_b, rt_sum, rt_v_n, rt_r_n, rt_fin;
  logic                          rt_ge;
  logic [17:0]                   rt_sat;

  // Operation results.
  logic [49:0] nsq_val, d_val;
  logic [31:0] m_val;
  logic [smcs_pkg::ROOT_W-1:0] v_val, w_val;
  logic [17:0] sd_val, ci_val, q_val;
  logic [35:0] t_val;
  logic [51:0] t2_val;
  logic [29:0] den_val;

  assign done = busy && (iter == '0);

  assign mul_acc_n = mul_b[0] ? mul_acc + mul_a : mul_acc;

  assign div_t     = {div_rem, div_n[smcs_pkg::DIV_N_W-1]};
  assign div_ge    = (div_t >= {1'b0, div_d});
  assign div_rem_n = div_ge ? smcs_pkg::DIV_D_W'(div_t - {1'b0, div_d})
                            : div_t[smcs_pkg::DIV_D_W-1:0];
  assign div_n_nx  = {div_n[smcs_pkg::DIV_N_W-2:0], div_ge};

  assign rt_sum = rt_r + rt_b;
  assign rt_ge  = (rt_v >= rt_sum);
  assign rt_v_n = rt_ge ? rt_v - rt_sum : rt_v;
  assign rt_r_n = rt_ge ? (rt_r >> 1) + rt_b : (rt_r >> 1);
  assign rt_fin = (rt_v_n > rt_r_n) ? rt_r_n + 1'b1 : rt_r_n;
  assign rt_sat = (rt_fin > smcs_pkg::ROOT_W'(smcs_pkg::Q18MAX)) ? smcs_pkg::Q18MAX
                                                                 : rt_fin[17:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      iter <= '0;
    end else if (cmd.start) begin
      busy <= 1'b1;
      case (cmd.op)
        smcs_pkg::OP_VAR, smcs_pkg::OP_W, smcs_pkg::OP_MEAN:
          iter <= smcs_pkg::DIV_STEPS - 1'b1;
        smcs_pkg::OP_SD, smcs_pkg::OP_CI:
          iter <= smcs_pkg::ROOT_STEPS - 1'b1;
        default:
          iter <= smcs_pkg::MUL_STEPS - 1'b1;
      endcase
    end else if (busy) begin
      if (iter == '0) busy <= 1'b0;
      else iter <= iter - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      mul_acc <= '0;
      div_rem <= '0;
      rt_r    <= '0;
      rt_b    <= smcs_pkg::ROOT_BIT0;
      case (cmd.op)
        smcs_pkg::OP_NSQ: begin
          mul_a <= smcs_pkg::MUL_P_W'(run_sq);
          mul_b <= smcs_pkg::MUL_B_W'(count);
        end
        smcs_pkg::OP_SQ: begin
          mul_a <= smcs_pkg::MUL_P_W'(smag);
          mul_b <= smag;
        end
        smcs_pkg::OP_NN1: begin
          mul_a <= smcs_pkg::MUL_P_W'(count);
          mul_b <= smcs_pkg::MUL_B_W'(count - 1'b1);
        end
        smcs_pkg::OP_SD2: begin
          mul_a <= smcs_pkg::MUL_P_W'(sd_val);
          mul_b <= smcs_pkg::MUL_B_W'(sd_val);
        end
        smcs_pkg::OP_SCALE: begin
          mul_a <= smcs_pkg::MUL_P_W'(t_val);
          mul_b <= smcs_pkg::SCALE_NUM;
        end
        smcs_pkg::OP_DEN: begin
          mul_a <= smcs_pkg::MUL_P_W'(count);
          mul_b <= smcs_pkg::SCALE_DEN;
        end
        smcs_pkg::OP_VAR: begin
          div_n <= {d_val, 16'b0};
          div_d <= m_val;
        end
        smcs_pkg::OP_W: begin
          div_n <= smcs_pkg::DIV_N_W'(t2_val);
          div_d <= smcs_pkg::DIV_D_W'(den_val);
        end
        smcs_pkg::OP_MEAN: begin
          div_n <= smcs_pkg::DIV_N_W'({smag, 8'b0}) + smcs_pkg::DIV_N_W'(count >> 1);
          div_d <= smcs_pkg::DIV_D_W'(count);
        end
        smcs_pkg::OP_SD: rt_v <= v_val;
        smcs_pkg::OP_CI: rt_v <= w_val;
        default: ;
      endcase
    end else if (busy) begin
      mul_acc <= mul_acc_n;
      mul_a   <= mul_a << 1;
      mul_b   <= mul_b >> 1;
      div_rem <= div_rem_n;
      div_n   <= div_n_nx;
      rt_v    <= rt_v_n;
      rt_r    <= rt_r_n;
      rt_b    <= rt_b >> 2;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      case (cmd.op)
        smcs_pkg::OP_NSQ:   nsq_val <= mul_acc_n[49:0];
        smcs_pkg::OP_SQ:    d_val   <= nsq_val - mul_acc_n[49:0];
        smcs_pkg::OP_NN1:   m_val   <= mul_acc_n[31:0];
        smcs_pkg::OP_VAR:   v_val   <= div_n_nx[smcs_pkg::ROOT_W-1:0];
        smcs_pkg::OP_SD:    sd_val  <= rt_sat;
        smcs_pkg::OP_SD2:   t_val   <= mul_acc_n[35:0];
        smcs_pkg::OP_SCALE: t2_val  <= mul_acc_n[51:0];
        smcs_pkg::OP_DEN:   den_val <= mul_acc_n[29:0];
        smcs_pkg::OP_W:     w_val   <= div_n_nx[smcs_pkg::ROOT_W-1:0];
        smcs_pkg::OP_CI:    ci_val  <= rt_sat;
        smcs_pkg::OP_MEAN:  q_val   <= div_n_nx[17:0];
        default: ;
      endcase
    end
  end

  // Result assembly and output register.
  logic [17:0] mean_res, std_res, ci_res, ci_cur;
  logic        more;

  assign mean_res = stats_ok ? (run_sum[smcs_pkg::SUM_W-1] ? 18'(-q_val) : q_val) : '0;
  assign std_res  = stats_ok ? sd_val : '0;
  assign ci_res   = stats_ok ? ci_val : '0;
  assign ci_cur   = stats_ok ? ci_val : last_ci;
  assign more     = !stats_ok ? 1'b1 :
                    (count > max_values) ? 1'b0 : (ci_cur > ci_threshold);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      last_ci  <= '0;
    end else if (cmd.load) begin
      m_tvalid <= 1'b1;
      if (stats_ok) last_ci <= ci_val;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      m_tdata <= {6'b0, more, stats_ok, ci_res, std_res, mean_res,
                  count, mode_cnt, mode_val};
    end
  end

  assign stat.clr_last = (clr_addr == '1);
  assign stat.enough   = (count >= effmin);
  assign stat.done     = done;
  assign stat.out_busy = m_tvalid && !m_tready;

endmodule

// ----- src/sample_mode_and_confidence_stats_core.sv -----
// Sample statistics core: one signed sample in, one result out per sample.
// The slave stream carries the sample; the master stream carries the mode,
// the counts, the mean, the standard deviation, the 95 percent confidence
// half-width (all statistics in Q.8) and the valid and more-needed flags.
// Three registers (minimum count, maximum count, interval threshold) are
// written through a plain write port; they must be written only while the
// core is idle, and the core itself does not enforce this.
// After reset the core clears its 1024-entry histogram memory, one entry a
// cycle, and takes no sample until the clearing pass is through.
// A sample whose count stays below the minimum passes the update, check and
// output states and is delivered through the output register; the core
// then returns to idle for the next sample. Otherwise the statistics run
// through a shift-add multiplier (6 passes), a restoring divider (3 passes)
// and a square root (2 passes), each pass begun from a start state, before
// the result is delivered. One sample is in work at a time.
// A finished result sits in the output register until taken; the core may
// accept the next sample meanwhile, and waits before delivering it while
// the receiver stalls.
module sample_mode_and_confidence_stats_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // [9:0] sample, [15:10] zero
  input  logic [smcs_pkg::S_TDATA_W-1:0]        s_tdata,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // [9:0] mode_value, [25:10] mode_count, [41:26] sample_count,
  // [59:42] mean_value, [77:60] std_dev, [95:78] conf_interval,
  // [96] stats_valid, [97] more_needed, [103:98] zero
  output logic [smcs_pkg::M_TDATA_W-1:0]        m_tdata,
  input  logic                                 cfg_we,
  input  logic [smcs_pkg::CFG_IDX_W-1:0]        cfg_addr,
  input  logic [smcs_pkg::CFG_W-1:0]            cfg_wdata
);

  smcs_pkg::cmd_t  cmd;
  smcs_pkg::stat_t stat;

  smcs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  smcs_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .s_tdata   (s_tdata),
    .s_accept  (s_tvalid & s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

endmodule
